FILE: hdl/ps2m_pkg.sv
`timescale 1ns / 1ps
package ps2m_pkg;

  localparam int POS_BITS_DEFAULT = 16;
  localparam int POS_RESET = 300;
  localparam int OUT_POS_BITS = 16;
  localparam int BUTTON_W = 3;
  localparam int M_TDATA_W = 40;

  localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
  localparam logic [7:0] YSIGN_MASK = 8'h20;
  localparam logic [7:0] XSIGN_MASK = 8'h10;
  localparam logic [7:0] START_MASK = 8'h08;
  localparam logic [7:0] BUTTON_MASK = 8'h07;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_DX = 2'd1,
    PH_DY = 2'd2
  } ps2m_phase_t;

  // complete packet handed from the framer to the position logic
  typedef struct packed {
    logic valid;
    logic at_dy;
    logic [7:0] flags;
    logic [7:0] dx;
    logic [7:0] dy;
  } ps2m_pkt_t;

endpackage

FILE: hdl/ps2m_framer.sv
`timescale 1ns / 1ps
module ps2m_framer
  import ps2m_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [7:0] data_byte,
  output ps2m_pkt_t pkt
);

  ps2m_phase_t phase;
  ps2m_phase_t phase_next;
  logic [7:0] held_flags;
  logic [7:0] held_dx;
  logic drop;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (phase)
        PH_START: phase_next = ((data_byte & START_MASK) != 8'd0) ? PH_DX : PH_START;
        PH_DX: phase_next = PH_DY;
        PH_DY: phase_next = PH_START;
        // the unused phase behaves like waiting for a start byte
        default: phase_next = ((data_byte & START_MASK) != 8'd0) ? PH_DX : PH_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      held_flags <= 8'd0;
      held_dx <= 8'd0;
    end else begin
      phase <= phase_next;
      if (accept && phase_next == PH_DX) begin
        held_flags <= data_byte;
      end
      if (accept && phase == PH_DX) begin
        held_dx <= data_byte;
      end
    end
  end

  // all three bytes equal, or either overflow bit set
  assign drop = (held_flags == held_dx && held_flags == data_byte)
                || ((held_flags & OVERFLOW_MASK) != 8'd0);

  always_comb begin
    pkt.at_dy = (phase == PH_DY);
    pkt.valid = accept && (phase == PH_DY) && !drop;
    pkt.flags = held_flags;
    pkt.dx = held_dx;
    pkt.dy = data_byte;
  end

endmodule

FILE: hdl/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// PS/2 mouse packet decoder. Takes one raw mouse byte per cycle on the s_ side and
// frames bytes into three-byte packets (flags, dx, dy); a packet starts only on a byte
// with bit 3 set. Packets with all bytes equal or an overflow bit set are dropped. Each
// good packet updates the X/Y position (POS_BITS wide, reset 300, Y grows downward) and
// the buttons, and one result appears on the m_ side the cycle after the third byte.
// The position registers are the output register: a new byte is taken every cycle, and
// s_tready drops only when a third byte is due while a result is still waiting.
module ps2_mouse_packet_decoder
  import ps2m_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,            // [7:0] data_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [15:0] pos_x, [31:16] pos_y, [34:32] button_bits
);

  ps2m_pkt_t pkt;
  logic accept;
  logic [POS_BITS-1:0] x_position;
  logic [POS_BITS-1:0] y_position;
  logic [BUTTON_W-1:0] button_state;
  logic [POS_BITS-1:0] dx_ext;
  logic [POS_BITS-1:0] dy_ext;
  logic [POS_BITS+OUT_POS_BITS-1:0] x_wide;
  logic [POS_BITS+OUT_POS_BITS-1:0] y_wide;

  assign s_tready = !pkt.at_dy || !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  ps2m_framer u_framer (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .data_byte(s_tdata),
    .pkt(pkt)
  );

  assign dx_ext = {{(POS_BITS-8){(pkt.flags & XSIGN_MASK) != 8'd0}}, pkt.dx};
  assign dy_ext = {{(POS_BITS-8){(pkt.flags & YSIGN_MASK) != 8'd0}}, pkt.dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position <= POS_BITS'(POS_RESET);
      y_position <= POS_BITS'(POS_RESET);
      button_state <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pkt.valid) begin
        x_position <= x_position + dx_ext;
        y_position <= y_position - dy_ext;
        button_state <= BUTTON_W'(pkt.flags & BUTTON_MASK);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // low 16 bits of the positions, zero-filled when the positions are narrower
  assign x_wide = {{OUT_POS_BITS{1'b0}}, x_position};
  assign y_wide = {{OUT_POS_BITS{1'b0}}, y_position};

  assign m_tdata = {{(M_TDATA_W - 2*OUT_POS_BITS - BUTTON_W){1'b0}}, button_state,
                    y_wide[OUT_POS_BITS-1:0], x_wide[OUT_POS_BITS-1:0]};

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pkt.valid |-> (!m_tvalid || m_tready))
    else $error("result produced while previous result pending");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    pkt.valid |=> m_tvalid)
    else $error("good packet gave no result");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !pkt.valid |=> ($stable(x_position) && $stable(y_position) && $stable(button_state)))
    else $error("position changed without a good packet");

  a_valid_needs_dy: assert property (@(posedge clk) disable iff (rst)
    pkt.valid |-> (pkt.at_dy && accept))
    else $error("packet completed outside the dy byte");

endmodule
